@@ hdl/sawm_pkg.sv @@
// shared constants and types for the sliding anagram window match block
`timescale 1ns / 1ps

package sawm_pkg;

  localparam int ACTION_W = 2;
  localparam int LETTER_W = 5;
  localparam int INDEX_W  = 32;

  localparam logic [ACTION_W-1:0] ACT_CLEAR   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_PATTERN = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_TEXT    = 2'd2;

  localparam logic [INDEX_W-1:0] INDEX_MAX = '1;

  // histogram update controls for one accepted word
  typedef struct packed {
    logic                clear;
    logic                pat_add;
    logic                win_add;
    logic                win_drop;
    logic [LETTER_W-1:0] add_bin;
    logic [LETTER_W-1:0] drop_bin;
  } hist_ctl_t;

endpackage

@@ hdl/sawm_item_if.sv @@
// input channel: action and letter with valid/ready
`timescale 1ns / 1ps

interface sawm_item_if;
  logic                          valid;
  logic                          ready;
  logic [sawm_pkg::ACTION_W-1:0] action;
  logic [sawm_pkg::LETTER_W-1:0] letter;

  modport source (output valid, output action, output letter, input ready);
  modport sink   (input valid, input action, input letter, output ready);
endinterface

@@ hdl/sawm_result_if.sv @@
// output channel: start index and overflow flag with valid/ready
`timescale 1ns / 1ps

interface sawm_result_if;
  logic                         valid;
  logic                         ready;
  logic [sawm_pkg::INDEX_W-1:0] start_index;
  logic                         pattern_overflow;

  modport source (output valid, output start_index, output pattern_overflow, input ready);
  modport sink   (input valid, input start_index, input pattern_overflow, output ready);
endinterface

@@ hdl/sliding_anagram_window_match.sv @@
// top level of the sliding anagram window match block
`timescale 1ns / 1ps

// usage
// - item channel: one word per handshake, action clear / pattern letter / text letter
//   plus a letter code; clear empties everything, pattern letters (before any text)
//   build the pattern histogram and set the window length
// - result channel: start_index of a text window whose letter counts equal the
//   pattern's, plus the sticky pattern_overflow flag
// - one word accepted per cycle while ready is high; every word is finished in the
//   cycle it is taken, and a result from a text letter goes to the output register
//   or, while that one is held, to the skid register; the histogram update and the
//   all-bin compare are done together ahead of the result register
// - the letter leaving the window comes from a delay-line ram read ahead from the
//   next-state pointers, with a bypass when the leaving letter is the one just written
// - results wait in an output register backed by a skid register; ready drops
//   only while both hold a result, so a stalled receiver stops the input after
//   two pending results
// - reset (synchronous, active high) behaves as a clear: histograms, counters,
//   overflow flag and output buffer empty; the delay-line ram is not cleared,
//   only entries written since the last clear are ever used
module sliding_anagram_window_match #(
  parameter int MAX_PATTERN = 64,
  parameter int ALPHABET    = 26
) (
  input  logic          clk,
  input  logic          rst,
  sawm_item_if.sink     item,
  sawm_result_if.source result
);

  localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LW = $clog2(MAX_PATTERN + 1);
  localparam int PW = LW + 1;
  localparam logic [LW-1:0] PLEN_MAX = LW'(MAX_PATTERN);
  localparam logic [AW-1:0] PTR_LAST = AW'(MAX_PATTERN - 1);
  localparam logic [PW-1:0] DEPTH_P  = PW'(MAX_PATTERN);

  // block state
  logic [LW-1:0]                plen;
  logic [LW-1:0]                plen_next;
  logic [AW-1:0]                wptr;
  logic [AW-1:0]                wptr_next;
  logic [sawm_pkg::INDEX_W-1:0] tpos;
  logic [sawm_pkg::INDEX_W-1:0] tpos_next;
  logic                         ovf;
  logic                         ovf_next;

  // delay line read-ahead
  logic [AW-1:0]                 rd_addr;
  logic [PW-1:0]                 rd_sum;
  logic [sawm_pkg::LETTER_W-1:0] ram_q;
  logic                          byp;
  logic [sawm_pkg::LETTER_W-1:0] byp_letter;
  logic [sawm_pkg::LETTER_W-1:0] gone;

  // word decode
  logic accept;
  logic letter_ok;
  logic is_clear;
  logic is_pat;
  logic is_text;
  logic win_on;
  logic full;
  logic reached;
  logic match;
  logic emit;
  logic [sawm_pkg::INDEX_W-1:0] start_calc;

  sawm_pkg::hist_ctl_t hctl;

  // output register and skid
  logic                         out_valid;
  logic [sawm_pkg::INDEX_W-1:0] out_index;
  logic                         out_ovf;
  logic                         skid_valid;
  logic [sawm_pkg::INDEX_W-1:0] skid_index;
  logic                         skid_ovf;
  logic                         out_fire;

  assign item.ready = ~skid_valid;
  assign accept     = item.valid & item.ready;
  assign letter_ok  = 32'(item.letter) < ALPHABET;

  assign is_clear = accept && (item.action == sawm_pkg::ACT_CLEAR);
  // pattern letters count only before the first text letter
  assign is_pat   = accept && (item.action == sawm_pkg::ACT_PATTERN) && letter_ok
                    && (tpos == '0);
  assign is_text  = accept && (item.action == sawm_pkg::ACT_TEXT) && letter_ok;
  assign win_on   = is_text && (plen != '0);
  assign full     = tpos >= sawm_pkg::INDEX_W'(plen);
  assign reached  = ({1'b0, tpos} + 33'd1) >= 33'(plen);
  assign gone     = byp ? byp_letter : ram_q;
  assign start_calc = tpos - sawm_pkg::INDEX_W'(plen) + sawm_pkg::INDEX_W'(1);

  always_comb begin
    hctl          = '0;
    hctl.clear    = is_clear;
    hctl.pat_add  = is_pat && (plen < PLEN_MAX);
    hctl.win_add  = win_on;
    hctl.win_drop = win_on && full;
    hctl.add_bin  = item.letter;
    hctl.drop_bin = gone;
  end

  sawm_hist #(
    .ALPHABET    (ALPHABET),
    .MAX_PATTERN (MAX_PATTERN)
  ) u_hist (
    .clk   (clk),
    .rst   (rst),
    .ctl   (hctl),
    .match (match)
  );

  assign emit = win_on && reached && match;

  // next state
  always_comb begin
    plen_next = plen;
    wptr_next = wptr;
    tpos_next = tpos;
    ovf_next  = ovf;
    if (is_clear) begin
      plen_next = '0;
      wptr_next = '0;
      tpos_next = '0;
      ovf_next  = 1'b0;
    end else if (is_pat) begin
      if (plen < PLEN_MAX) begin
        plen_next = plen + LW'(1);
      end else begin
        ovf_next = 1'b1;
      end
    end else if (is_text) begin
      // text position saturates
      if (tpos != sawm_pkg::INDEX_MAX) begin
        tpos_next = tpos + sawm_pkg::INDEX_W'(1);
      end
      if (win_on) begin
        wptr_next = (wptr == PTR_LAST) ? '0 : wptr + AW'(1);
      end
    end
  end

  // address of the letter that leaves the window on the next text word
  always_comb begin
    rd_sum = PW'(wptr_next) + DEPTH_P - PW'(plen_next);
    if (rd_sum >= DEPTH_P) begin
      rd_sum = rd_sum - DEPTH_P;
    end
    rd_addr = AW'(rd_sum);
  end

  sawm_ram #(
    .WIDTH (sawm_pkg::LETTER_W),
    .DEPTH (MAX_PATTERN)
  ) u_delay (
    .clk   (clk),
    .we    (win_on),
    .waddr (wptr),
    .wdata (item.letter),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      plen <= '0;
      wptr <= '0;
      tpos <= '0;
      ovf  <= 1'b0;
      byp  <= 1'b0;
    end else begin
      plen <= plen_next;
      wptr <= wptr_next;
      tpos <= tpos_next;
      ovf  <= ovf_next;
      // ram reads old data on a same-address write, so forward the new letter
      byp  <= win_on && (wptr == rd_addr);
    end
    byp_letter <= item.letter;
  end

  // result buffering
  assign out_fire = out_valid & result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (emit) begin
      if (!out_valid || out_fire) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        out_index <= skid_index;
        out_ovf   <= skid_ovf;
      end
    end else if (emit) begin
      if (!out_valid || out_fire) begin
        out_index <= start_calc;
        out_ovf   <= ovf;
      end else begin
        skid_index <= start_calc;
        skid_ovf   <= ovf;
      end
    end
  end

  assign result.valid            = out_valid;
  assign result.start_index      = out_index;
  assign result.pattern_overflow = out_ovf;

endmodule

@@ hdl/sawm_ram.sv @@
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module sawm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/sawm_hist.sv @@
// pattern and window histograms with the all-bin match compare
`timescale 1ns / 1ps

module sawm_hist #(
  parameter int ALPHABET    = 26,
  parameter int MAX_PATTERN = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  sawm_pkg::hist_ctl_t ctl,
  output logic                match
);

  localparam int CW = $clog2(MAX_PATTERN + 1);

  logic [CW-1:0] pat_counts [ALPHABET];
  logic [CW-1:0] win_counts [ALPHABET];
  logic [CW-1:0] win_counts_next [ALPHABET];
  logic [CW-1:0] pat_counts_next [ALPHABET];

  always_comb begin
    for (int b = 0; b < ALPHABET; b++) begin
      pat_counts_next[b] = pat_counts[b];
      win_counts_next[b] = win_counts[b];
      if (ctl.pat_add && (32'(ctl.add_bin) == b)) begin
        pat_counts_next[b] = pat_counts[b] + CW'(1);
      end
      // drop is guarded against an empty bin, then the new letter adds
      if (ctl.win_drop && (32'(ctl.drop_bin) == b) && (win_counts[b] != '0)) begin
        win_counts_next[b] = win_counts[b] - CW'(1);
      end
      if (ctl.win_add && (32'(ctl.add_bin) == b)) begin
        win_counts_next[b] = win_counts_next[b] + CW'(1);
      end
    end
  end

  // compare the updated window against the pattern
  always_comb begin
    match = 1'b1;
    for (int b = 0; b < ALPHABET; b++) begin
      if (win_counts_next[b] != pat_counts[b]) begin
        match = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      for (int b = 0; b < ALPHABET; b++) begin
        pat_counts[b] <= '0;
        win_counts[b] <= '0;
      end
    end else begin
      for (int b = 0; b < ALPHABET; b++) begin
        pat_counts[b] <= pat_counts_next[b];
        win_counts[b] <= win_counts_next[b];
      end
    end
  end

endmodule
